>>> rtl/core/rfp_pkg.sv
package rfp_pkg;

   // relocation types carried on the request tuser
   typedef enum logic [7:0] {
      KIND_NONE  = 8'd0,
      KIND_REL8  = 8'd1,
      KIND_ABS32 = 8'd2,
      KIND_ABS_H = 8'd3,
      KIND_ABS_M = 8'd4,
      KIND_ABS_L = 8'd5,
      KIND_REL21 = 8'd6,
      KIND_REL_H = 8'd7,
      KIND_REL_M = 8'd8,
      KIND_REL_L = 8'd9
   } kind_type;

   localparam int KIND_W  = 8;
   localparam int VALUE_W = 64;
   localparam int WORD_W  = 32;
   localparam int IMM_W   = 13;

   // top bits of the second byte of an ext word
   localparam logic [2:0] EXT_TAG = 3'b110;

   // after the subtract stage
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [WORD_W-1:0]  orig;
      logic [WORD_W-1:0]  val_lo;
      logic [VALUE_W-1:0] sv2;
      logic [IMM_W-1:0]   rel_h_imm;
   } sub_type;

   // after the halving stage
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [WORD_W-1:0]  orig;
      logic [WORD_W-1:0]  val_lo;
      logic               odd;
      logic [VALUE_W-1:0] disp;
      logic [IMM_W-1:0]   rel_h_imm;
      logic [IMM_W-1:0]   rel_m_imm;
   } half_type;

endpackage

>>> rtl/core/rfp_sub.sv
module rfp_sub (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [rfp_pkg::KIND_W-1:0]     in_kind,
   input  logic [rfp_pkg::VALUE_W-1:0]    in_value,
   input  logic [rfp_pkg::WORD_W-1:0]     in_orig,
   output logic                           out_valid,
   output rfp_pkg::sub_type               out_data
);

   logic             valid_ff;
   rfp_pkg::sub_type data_ff;
   rfp_pkg::sub_type data_in;
   logic [34:0]      sv4;

   // value minus two over the full width, value minus four for the high piece
   always_comb begin
      sv4               = in_value[34:0] - 35'd4;
      data_in.kind      = in_kind;
      data_in.orig      = in_orig;
      data_in.val_lo    = in_value[rfp_pkg::WORD_W-1:0];
      data_in.sv2       = in_value - 64'd2;
      data_in.rel_h_imm = sv4[34:22];
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/rfp_half.sv
module rfp_half (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  rfp_pkg::sub_type  in_data,
   output logic              out_valid,
   output rfp_pkg::half_type out_data
);

   logic              valid_ff;
   rfp_pkg::half_type data_ff;
   rfp_pkg::half_type data_in;
   logic [63:0]       biased;

   // halve toward zero: add one to negative values, then shift arithmetically
   always_comb begin
      biased            = in_data.sv2 + {63'd0, in_data.sv2[63]};
      data_in.kind      = in_data.kind;
      data_in.orig      = in_data.orig;
      data_in.val_lo    = in_data.val_lo;
      data_in.odd       = in_data.sv2[0];
      data_in.disp      = {biased[63], biased[63:1]};
      data_in.rel_h_imm = in_data.rel_h_imm;
      data_in.rel_m_imm = in_data.sv2[21:9];
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/rfp_patch.sv
module rfp_patch (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  rfp_pkg::half_type           in_data,
   output logic                        out_valid,
   output logic [rfp_pkg::WORD_W-1:0]  out_word,
   output logic                        out_misaligned,
   output logic                        out_out_of_range,
   output logic                        out_unknown_type
);

   logic                       valid_ff;
   logic [rfp_pkg::WORD_W-1:0] word_ff;
   logic                       mis_ff;
   logic                       oor_ff;
   logic                       unk_ff;
   logic [rfp_pkg::WORD_W-1:0] word_in;
   logic                       mis_in;
   logic                       oor_in;
   logic                       unk_in;
   logic                       fits8;
   logic                       fits21;

   // ext word: low byte of the immediate, then the tag with its high five bits
   function automatic logic [15:0] ext_word(input logic [rfp_pkg::IMM_W-1:0] imm);
      ext_word = {rfp_pkg::EXT_TAG, imm[12:8], imm[7:0]};
   endfunction

   // signed range checks: all bits above the sign bit equal the sign bit
   always_comb begin
      fits8  = (&in_data.disp[63:7])  | ~(|in_data.disp[63:7]);
      fits21 = (&in_data.disp[63:20]) | ~(|in_data.disp[63:20]);
   end

   // patch the bytes by relocation type
   always_comb begin
      word_in = in_data.orig;
      mis_in  = 1'b0;
      oor_in  = 1'b0;
      unk_in  = 1'b0;
      unique case (in_data.kind)
         rfp_pkg::KIND_NONE: begin
            word_in = in_data.orig;
         end
         rfp_pkg::KIND_REL8: begin
            mis_in       = in_data.odd;
            oor_in       = ~fits8;
            word_in[7:0] = in_data.disp[7:0];
         end
         rfp_pkg::KIND_ABS32: begin
            word_in = in_data.val_lo;
         end
         rfp_pkg::KIND_ABS_H: begin
            word_in[15:0] = ext_word(in_data.val_lo[31:19]);
         end
         rfp_pkg::KIND_ABS_M: begin
            word_in[15:0] = ext_word(in_data.val_lo[18:6]);
         end
         rfp_pkg::KIND_ABS_L: begin
            word_in[7:0]  = in_data.orig[7:0]  | {in_data.val_lo[3:0], 4'd0};
            word_in[15:8] = in_data.orig[15:8] | {6'd0, in_data.val_lo[5:4]};
         end
         rfp_pkg::KIND_REL21: begin
            mis_in         = in_data.odd;
            oor_in         = ~fits21;
            word_in[15:0]  = ext_word(in_data.disp[20:8]);
            word_in[23:16] = in_data.disp[7:0];
         end
         rfp_pkg::KIND_REL_H: begin
            word_in[15:0] = ext_word(in_data.rel_h_imm);
         end
         rfp_pkg::KIND_REL_M: begin
            word_in[15:0] = ext_word(in_data.rel_m_imm);
         end
         rfp_pkg::KIND_REL_L: begin
            word_in[7:0] = in_data.val_lo[8:1];
         end
         default: begin
            unk_in = 1'b1;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         word_ff <= word_in;
         mis_ff  <= mis_in;
         oor_ff  <= oor_in;
         unk_ff  <= unk_in;
      end
   end

   assign out_valid        = valid_ff;
   assign out_word         = word_ff;
   assign out_misaligned   = mis_ff;
   assign out_out_of_range = oor_ff;
   assign out_unknown_type = unk_ff;

endmodule

>>> rtl/core/reloc_field_patcher_top.sv
// Relocation field patcher: each request word carries a relocation type, a
// 64-bit relocated value and the four original little-endian instruction
// bytes; each response word carries the patched bytes and three error flags
// (misaligned, out of range, unknown type). Flagged words are still patched,
// but unknown types keep the original bytes. The block takes one word per
// clock unless stalled, and each word passes through three register stages
// (subtract, halve, patch with output register); a stage advances whenever
// it is empty or the stage after it advances, so bubbles are squeezed out and
// a held response only stalls the words behind it once every stage is full.
module reloc_field_patcher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // value[63:0], orig_word[95:64]
   input  logic [7:0]  req_tuser,   // kind[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // patched_word[31:0]
   output logic [2:0]  rsp_tuser    // misaligned[0], out_of_range[1], unknown_type[2]
);

   logic              sub_valid;
   logic              half_valid;
   rfp_pkg::sub_type  sub_data;
   rfp_pkg::half_type half_data;
   logic              sub_adv;
   logic              half_adv;
   logic              out_adv;

   // stall chain from the response side back to the request side
   assign out_adv    = ~rsp_tvalid | rsp_tready;
   assign half_adv   = ~half_valid | out_adv;
   assign sub_adv    = ~sub_valid  | half_adv;
   assign req_tready = sub_adv;

   rfp_sub u_sub (
      .clock     (clock),
      .reset     (reset),
      .advance   (sub_adv),
      .in_valid  (req_tvalid),
      .in_kind   (req_tuser),
      .in_value  (req_tdata[63:0]),
      .in_orig   (req_tdata[95:64]),
      .out_valid (sub_valid),
      .out_data  (sub_data)
   );

   rfp_half u_half (
      .clock     (clock),
      .reset     (reset),
      .advance   (half_adv),
      .in_valid  (sub_valid),
      .in_data   (sub_data),
      .out_valid (half_valid),
      .out_data  (half_data)
   );

   rfp_patch u_patch (
      .clock            (clock),
      .reset            (reset),
      .advance          (out_adv),
      .in_valid         (half_valid),
      .in_data          (half_data),
      .out_valid        (rsp_tvalid),
      .out_word         (rsp_tdata),
      .out_misaligned   (rsp_tuser[0]),
      .out_out_of_range (rsp_tuser[1]),
      .out_unknown_type (rsp_tuser[2])
   );

   // an accepted word lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> sub_valid)
      else $error("accepted word missing from first stage");

   // a stalled middle stage keeps its word
   assert property (@(posedge clock) disable iff (reset)
      half_valid && !out_adv |=> half_valid && $stable(half_data))
      else $error("middle stage lost or changed a stalled word");

   // an unknown type never also reports displacement errors
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> !rsp_tuser[0] && !rsp_tuser[1])
      else $error("unknown type with displacement flags");

   // a full pipeline with a held response accepts nothing
   assert property (@(posedge clock) disable iff (reset)
      sub_valid && half_valid && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted into a full pipeline");

endmodule

>>> tb/tb_reloc_field_patcher_top.sv
`timescale 1ns / 1ps

module tb_reloc_field_patcher_top;

   // first relocation type code that the block does not know
   localparam logic [7:0] KIND_FIRST_UNKNOWN = rfp_pkg::KIND_REL_L + 8'd1;
   // highest code the kind field can carry
   localparam logic [7:0] KIND_CODE_MAX = 8'hFF;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      logic [7:0]  kind;
      logic [63:0] value;
      logic [31:0] orig;
      bit          pause;   // wait for an empty pipe before offering this word
   } patch_req_type;

   typedef struct {
      logic [31:0] word;
      logic        mis;
      logic        oor;
      logic        unk;
   } patch_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // value[63:0], orig_word[95:64]
   logic [7:0]  req_tuser = '0;   // kind[7:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // patched_word[31:0]
   logic [2:0]  rsp_tuser;        // misaligned[0], out_of_range[1], unknown_type[2]

   patch_req_type pending_reqs[$];
   patch_rsp_type expected_patch[$];
   patch_req_type cur_req;
   int            mismatch_count = 0;
   int            taken_count = 0;
   int            cycle_count = 0;
   int            burst_left = 0;
   int            gap_left = 0;
   logic          long_hold = 1'b0;
   int            hold_left = 0;
   bit            hold_done = 1'b0;
   int            rdy_left = 0;
   int            rdy_mode = 0;

   reloc_field_patcher_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // signed halving, truncated toward zero
   function automatic logic [63:0] half_trunc(logic [63:0] x);
      logic [63:0] mag;
      if (x[63]) begin
         mag = 64'd0 - x;
         return 64'd0 - (mag >> 1);
      end
      return x >> 1;
   endfunction

   // true when the 64-bit pattern fits a signed field of n bits
   function automatic bit fits_signed(logic [63:0] v, int n);
      logic [63:0] bias;
      bias = 64'd1 << (n - 1);
      return (v + bias) < (64'd1 << n);
   endfunction

   // ext word: imm low byte, then 110 and the high five imm bits
   function automatic logic [31:0] ext_word(logic [31:0] w, logic [12:0] imm);
      logic [31:0] r;
      r = w;
      r[7:0]  = imm[7:0];
      r[15:8] = {3'b110, imm[12:8]};
      return r;
   endfunction

   // expected patched bytes and flags for one relocation word
   function automatic patch_rsp_type patch_site(patch_req_type r);
      patch_rsp_type p;
      logic [63:0] sv;
      logic [63:0] d;
      logic [63:0] t;
      p.word = r.orig;
      p.mis  = 1'b0;
      p.oor  = 1'b0;
      p.unk  = 1'b0;
      case (r.kind)
         rfp_pkg::KIND_NONE: ;
         rfp_pkg::KIND_REL8: begin
            sv = r.value - 64'd2;
            d  = half_trunc(sv);
            p.mis = sv[0];
            p.oor = !fits_signed(d, 8);
            p.word[7:0] = d[7:0];
         end
         rfp_pkg::KIND_ABS32: p.word = r.value[31:0];
         rfp_pkg::KIND_ABS_H: p.word = ext_word(p.word, r.value[31:19]);
         rfp_pkg::KIND_ABS_M: p.word = ext_word(p.word, r.value[18:6]);
         rfp_pkg::KIND_ABS_L: begin
            p.word[7:0]  = p.word[7:0] | {r.value[3:0], 4'b0000};
            p.word[15:8] = p.word[15:8] | {6'b000000, r.value[5:4]};
         end
         rfp_pkg::KIND_REL21: begin
            sv = r.value - 64'd2;
            d  = half_trunc(sv);
            p.mis = sv[0];
            p.oor = !fits_signed(d, 21);
            p.word = ext_word(p.word, d[20:8]);
            p.word[23:16] = d[7:0];
         end
         rfp_pkg::KIND_REL_H: begin
            t = r.value - 64'd4;
            p.word = ext_word(p.word, t[34:22]);
         end
         rfp_pkg::KIND_REL_M: begin
            t = r.value - 64'd2;
            p.word = ext_word(p.word, t[21:9]);
         end
         rfp_pkg::KIND_REL_L: p.word[7:0] = r.value[8:1];
         default: p.unk = 1'b1;
      endcase
      return p;
   endfunction

   task automatic flag_error(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic add_req(logic [7:0] kind, logic [63:0] value, logic [31:0] orig,
                          bit pause = 1'b0);
      patch_req_type r;
      r.kind  = kind;
      r.value = value;
      r.orig  = orig;
      r.pause = pause;
      pending_reqs.push_back(r);
   endtask

   // mix of full-width, small, mid-size and near-limit displacements
   function automatic logic [63:0] rand_value();
      logic [31:0] r;
      longint      d;
      r = $urandom;
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return {{54{r[9]}}, r[9:0]};
         2: return {{41{r[22]}}, r[22:0]};
         default: begin
            case ($urandom_range(0, 3))
               0: d = 127;
               1: d = -128;
               2: d = (64'sd1 <<< 20) - 1;
               default: d = -(64'sd1 <<< 20);
            endcase
            d = d + $urandom_range(0, 2) - 1;
            return 2 + 2 * d + $urandom_range(0, 1);
         end
      endcase
   endfunction

   // sender: bursts of words with random gaps, optional drain pauses
   always @(posedge clock) begin : drive_proc
      patch_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         burst_left = $urandom_range(1, 40);
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_patch.push_back(patch_site(cur_req));
            taken_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_reqs[0].pause && expected_patch.size() != 0) begin
               req_tvalid <= 1'b0;
            end else if (gap_left > 0 && !long_hold) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               nxt = pending_reqs.pop_front();
               cur_req = nxt;
               req_tvalid <= 1'b1;
               req_tdata  <= {nxt.orig, nxt.value};
               req_tuser  <= nxt.kind;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end
            end
         end
      end
   end

   // one long receiver hold-off partway through, so the pipe backs up
   always @(posedge clock) begin
      if (reset) begin
         long_hold <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && taken_count >= 200) begin
         long_hold <= 1'b1;
         hold_left <= 80;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1) begin
            long_hold <= 1'b0;
         end
      end
   end

   // receiver: check each word, stall on a pattern of phases
   always @(posedge clock) begin : check_proc
      patch_rsp_type exp_rsp;
      bit            rdy_bit;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_patch.size() == 0) begin
               flag_error($sformatf("unexpected word %h flags %b", rsp_tdata, rsp_tuser));
            end else begin
               exp_rsp = expected_patch.pop_front();
               if (rsp_tdata !== exp_rsp.word)
                  flag_error($sformatf("patched_word %h, want %h", rsp_tdata, exp_rsp.word));
               if (rsp_tuser[0] !== exp_rsp.mis)
                  flag_error($sformatf("misaligned %b, want %b", rsp_tuser[0], exp_rsp.mis));
               if (rsp_tuser[1] !== exp_rsp.oor)
                  flag_error($sformatf("out_of_range %b, want %b", rsp_tuser[1], exp_rsp.oor));
               if (rsp_tuser[2] !== exp_rsp.unk)
                  flag_error($sformatf("unknown_type %b, want %b", rsp_tuser[2], exp_rsp.unk));
            end
         end
         if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 2);
            rdy_left = $urandom_range(5, 60);
         end
         rdy_left--;
         case (rdy_mode)
            0: rdy_bit = 1'b1;
            1: rdy_bit = 1'($urandom_range(0, 1));
            default: rdy_bit = ($urandom_range(0, 3) == 0);
         endcase
         rsp_tready <= rdy_bit && !long_hold;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stim_proc
      logic [7:0] k;
      // directed: limits, every type, flag corners
      add_req(rfp_pkg::KIND_NONE,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      add_req(rfp_pkg::KIND_NONE,  64'h0,                   32'h0);
      add_req(rfp_pkg::KIND_REL8,  64'd256,                 32'hA5A5_5A5A);
      add_req(rfp_pkg::KIND_REL8,  64'd258,                 32'hA5A5_5A5A);
      add_req(rfp_pkg::KIND_REL8,  -64'sd254,               32'h1234_5678);
      add_req(rfp_pkg::KIND_REL8,  -64'sd256,               32'h1234_5678);
      add_req(rfp_pkg::KIND_REL8,  64'd3,                   32'hFFFF_FFFF);
      add_req(rfp_pkg::KIND_REL8,  64'd1,                   32'h0);
      add_req(rfp_pkg::KIND_REL8,  -64'sd1,                 32'h0);
      add_req(rfp_pkg::KIND_REL8,  64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
      add_req(rfp_pkg::KIND_REL8,  64'h8000_0000_0000_0001, 32'h0);
      add_req(rfp_pkg::KIND_ABS32, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
      add_req(rfp_pkg::KIND_ABS32, 64'h0,                   32'hFFFF_FFFF);
      add_req(rfp_pkg::KIND_ABS_H, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
      add_req(rfp_pkg::KIND_ABS_M, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      add_req(rfp_pkg::KIND_ABS_L, 64'h3F,                  32'h0);
      add_req(rfp_pkg::KIND_ABS_L, 64'hFFFF_FFFF_FFFF_FFC0, 32'hFFFF_FFFF);
      add_req(rfp_pkg::KIND_REL21, 64'd2 + 64'd2 * ((64'd1 << 20) - 64'd1), 32'hFFFF_FFFF);
      add_req(rfp_pkg::KIND_REL21, 64'd2 + 64'd2 * (64'd1 << 20),           32'h0);
      add_req(rfp_pkg::KIND_REL21, 64'd2 - 64'd2 * (64'd1 << 20),           32'hFFFF_FFFF);
      add_req(rfp_pkg::KIND_REL21, 64'd2 - 64'd2 * ((64'd1 << 20) + 64'd1), 32'h0);
      add_req(rfp_pkg::KIND_REL_H, 64'h0,                   32'hFFFF_FFFF);
      add_req(rfp_pkg::KIND_REL_M, 64'h0,                   32'h0);
      add_req(rfp_pkg::KIND_REL_L, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
      add_req(KIND_FIRST_UNKNOWN,  64'hFFFF_FFFF_FFFF_FFFF, 32'h8765_4321);
      add_req(KIND_CODE_MAX,       64'h0,                   32'hFFFF_FFFF);

      // random words, mostly known types; two drain pauses along the way
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 9) == 0)
            k = 8'($urandom_range(KIND_FIRST_UNKNOWN, KIND_CODE_MAX));
         else
            k = 8'($urandom_range(rfp_pkg::KIND_NONE, rfp_pkg::KIND_REL_L));
         add_req(k, rand_value(), $urandom, (i == 350) || (i == 600));
      end

      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // wait for every word to go in and every response to come back
      while (pending_reqs.size() != 0 || req_tvalid || expected_patch.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_patch.size() != 0)
         flag_error($sformatf("%0d responses never arrived", expected_patch.size()));
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
